// ===== rtl/assert_macros.svh =====
// shared assertion macros, clocked on the rising edge and cut off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on clk_i, quiet while rst_ni is low
`define RTI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same check with an explicit clock and reset
`define RTI_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

`endif

// ===== rtl/rti_pkg.sv =====
`timescale 1ns / 1ps
package rti_pkg;

  localparam int COORD_BITS = 32;
  localparam int FRAC_BITS  = 16;
  localparam int EDGE_BITS  = COORD_BITS + 1;
  localparam int ACC_BITS   = 64;
  localparam int EPS_BITS   = 16;
  localparam int UV_BITS    = FRAC_BITS + 1;
  localparam int ADDR_BITS  = 4;
  localparam int DATA_BITS  = 32;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [EDGE_BITS-1:0]  edge_t;

  localparam coord_t              DIR_X_RESET = '0;
  localparam coord_t              DIR_Y_RESET = '0;
  localparam coord_t              DIR_Z_RESET = -(coord_t'(1) <<< FRAC_BITS);
  localparam logic [EPS_BITS-1:0] DET_EPS_RESET = EPS_BITS'(66);

  typedef enum logic [1:0] {
    REG_DIR_X,
    REG_DIR_Y,
    REG_DIR_Z,
    REG_DET_EPS
  } reg_idx_e;

  typedef struct packed {
    coord_t origin_x;
    coord_t origin_y;
    coord_t origin_z;
    coord_t vertex0_x;
    coord_t vertex0_y;
    coord_t vertex0_z;
    coord_t vertex1_x;
    coord_t vertex1_y;
    coord_t vertex1_z;
    coord_t vertex2_x;
    coord_t vertex2_y;
    coord_t vertex2_z;
  } in_item_t;

  typedef struct packed {
    logic               hit;
    coord_t             distance_t;
    logic [UV_BITS-1:0] bary_u;
    logic [UV_BITS-1:0] bary_v;
  } out_item_t;

  // origin offset and the two triangle edges, all relative to vertex 0
  typedef struct packed {
    edge_t sv_x;
    edge_t sv_y;
    edge_t sv_z;
    edge_t ea_x;
    edge_t ea_y;
    edge_t ea_z;
    edge_t eb_x;
    edge_t eb_y;
    edge_t eb_z;
  } edge_item_t;

  typedef struct packed {
    coord_t              dir_x;
    coord_t              dir_y;
    coord_t              dir_z;
    logic [EPS_BITS-1:0] det_epsilon;
  } cfg_t;

endpackage

// ===== rtl/rti_front.sv =====
`timescale 1ns / 1ps
module rti_front import rti_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_item_t   in_item_i,
  output logic       edge_valid_o,
  input  logic       edge_stall_i,
  output edge_item_t edge_item_o
);

  logic       vld_q;
  edge_item_t item_q, item_d;

  always_comb begin
    item_d.sv_x = EDGE_BITS'(in_item_i.origin_x)  - EDGE_BITS'(in_item_i.vertex0_x);
    item_d.sv_y = EDGE_BITS'(in_item_i.origin_y)  - EDGE_BITS'(in_item_i.vertex0_y);
    item_d.sv_z = EDGE_BITS'(in_item_i.origin_z)  - EDGE_BITS'(in_item_i.vertex0_z);
    item_d.ea_x = EDGE_BITS'(in_item_i.vertex1_x) - EDGE_BITS'(in_item_i.vertex0_x);
    item_d.ea_y = EDGE_BITS'(in_item_i.vertex1_y) - EDGE_BITS'(in_item_i.vertex0_y);
    item_d.ea_z = EDGE_BITS'(in_item_i.vertex1_z) - EDGE_BITS'(in_item_i.vertex0_z);
    item_d.eb_x = EDGE_BITS'(in_item_i.vertex2_x) - EDGE_BITS'(in_item_i.vertex0_x);
    item_d.eb_y = EDGE_BITS'(in_item_i.vertex2_y) - EDGE_BITS'(in_item_i.vertex0_y);
    item_d.eb_z = EDGE_BITS'(in_item_i.vertex2_z) - EDGE_BITS'(in_item_i.vertex0_z);
  end

  assign in_stall_o   = vld_q & edge_stall_i;
  assign edge_valid_o = vld_q;
  assign edge_item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item_q <= item_d;
    end
  end

endmodule

// ===== rtl/rti_queue.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rti_queue import rti_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_valid_i,
  output logic       push_stall_o,
  input  edge_item_t push_item_i,
  output logic       pop_valid_o,
  input  logic       pop_stall_i,
  output edge_item_t pop_item_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  edge_item_t      mem_q [DEPTH];
  logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]   count_q;
  logic            push, pop;

  assign push_stall_o = (count_q == CW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i & ~push_stall_o;
  assign pop          = pop_valid_o & ~pop_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + CW'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  `RTI_ASSERT(a_count_bound, count_q <= CW'(DEPTH), "queue count beyond depth")
  `RTI_ASSERT(a_count_up, (push && !pop) |=> (count_q == $past(count_q) + CW'(1)),
              "queue count lost a push")

endmodule

// ===== rtl/rti_back.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rti_back import rti_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  edge_item_t in_item_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_item_t  out_item_o
);

  localparam int C    = COORD_BITS;
  localparam int E    = EDGE_BITS;
  localparam int F    = FRAC_BITS;
  localparam int A    = ACC_BITS;
  localparam int HALF = A / 2;
  localparam int PX   = 2 * E;
  localparam int PL   = E + HALF + 1;
  localparam int W4   = PL + HALF;
  localparam int Q    = A + F;

  localparam logic [A-1:0] ONE_FIX   = A'(1) << F;
  localparam logic [Q-1:0] CAP       = Q'(1) << (A - 2);
  localparam logic [A-1:0] T_MAX     = (A'(1) << (C - 1)) - A'(1);
  localparam logic [A-1:0] T_MIN_MAG = A'(1) << (C - 1);

  // product of a cross term, scaled back and wrapped to the accumulator width
  function automatic logic signed [A-1:0] fix_x(input logic signed [PX-1:0] p);
    logic signed [PX-1:0] s;
    s = p >>> F;
    return A'(s);
  endfunction

  // rejoin the split halves of a dot term, scale back and wrap
  function automatic logic signed [A-1:0] fix_d(input logic signed [PL-1:0] hi,
                                                 input logic signed [PL-1:0] lo);
    logic signed [W4-1:0] f;
    f = (W4'(hi) <<< HALF) + W4'(lo);
    return f[F+A-1:F];
  endfunction

  function automatic logic [A-1:0] mag(input logic [A-1:0] x);
    return x[A-1] ? (A'(0) - x) : x;
  endfunction

  logic en;
  logic [4:1] pv_q;
  logic [Q:0] dv_q;
  logic       out_vld_q;
  out_item_t  out_item_q, out_item_d;

  assign en          = ~out_vld_q | ~out_stall_i;
  assign in_stall_o  = ~en;
  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_item_q;

  // stage 1: cross product terms for h = d x eb and k = s x ea
  logic signed [PX-1:0] xp_q [12];
  logic signed [PX-1:0] xp_d [12];
  edge_item_t           e1_q, e2_q;

  always_comb begin
    xp_d[0]  = $signed(cfg_i.dir_y) * $signed(in_item_i.eb_z);
    xp_d[1]  = $signed(cfg_i.dir_z) * $signed(in_item_i.eb_y);
    xp_d[2]  = $signed(cfg_i.dir_z) * $signed(in_item_i.eb_x);
    xp_d[3]  = $signed(cfg_i.dir_x) * $signed(in_item_i.eb_z);
    xp_d[4]  = $signed(cfg_i.dir_x) * $signed(in_item_i.eb_y);
    xp_d[5]  = $signed(cfg_i.dir_y) * $signed(in_item_i.eb_x);
    xp_d[6]  = $signed(in_item_i.sv_y) * $signed(in_item_i.ea_z);
    xp_d[7]  = $signed(in_item_i.sv_z) * $signed(in_item_i.ea_y);
    xp_d[8]  = $signed(in_item_i.sv_z) * $signed(in_item_i.ea_x);
    xp_d[9]  = $signed(in_item_i.sv_x) * $signed(in_item_i.ea_z);
    xp_d[10] = $signed(in_item_i.sv_x) * $signed(in_item_i.ea_y);
    xp_d[11] = $signed(in_item_i.sv_y) * $signed(in_item_i.ea_x);
  end

  // stage 2: h and k vectors
  logic signed [A-1:0] hv_q [3];
  logic signed [A-1:0] kv_q [3];

  // stage 3: dot terms, the wide operand split into halves
  logic signed [PL-1:0] lo_q [12];
  logic signed [PL-1:0] hi_q [12];
  logic signed [PL-1:0] lo_d [12];
  logic signed [PL-1:0] hi_d [12];
  logic signed [A-1:0]  aop [12];
  logic signed [E-1:0]  bop [12];

  always_comb begin
    aop[0]  = hv_q[0];  bop[0]  = e2_q.ea_x;
    aop[1]  = hv_q[1];  bop[1]  = e2_q.ea_y;
    aop[2]  = hv_q[2];  bop[2]  = e2_q.ea_z;
    aop[3]  = hv_q[0];  bop[3]  = e2_q.sv_x;
    aop[4]  = hv_q[1];  bop[4]  = e2_q.sv_y;
    aop[5]  = hv_q[2];  bop[5]  = e2_q.sv_z;
    aop[6]  = kv_q[0];  bop[6]  = E'(cfg_i.dir_x);
    aop[7]  = kv_q[1];  bop[7]  = E'(cfg_i.dir_y);
    aop[8]  = kv_q[2];  bop[8]  = E'(cfg_i.dir_z);
    aop[9]  = kv_q[0];  bop[9]  = e2_q.eb_x;
    aop[10] = kv_q[1];  bop[10] = e2_q.eb_y;
    aop[11] = kv_q[2];  bop[11] = e2_q.eb_z;
    for (int i = 0; i < 12; i++) begin
      lo_d[i] = $signed({1'b0, aop[i][HALF-1:0]}) * bop[i];
      hi_d[i] = $signed(aop[i][A-1:HALF]) * bop[i];
    end
  end

  // stage 4: determinant and the three numerators
  logic signed [A-1:0] det_q, nu_q, nv_q, nt_q;

  // divider entry and one quotient bit per stage, lanes u, v, t
  logic [A-1:0] rem_q [Q+1][3];
  logic [Q-1:0] z_q   [Q+1][3];
  logic [A-1:0] dm_q  [Q+1];
  logic         neg_q [Q+1][3];
  logic         miss_q[Q+1];

  logic [A-1:0] dm0, nm0 [3];
  logic         sg0 [3];

  always_comb begin
    dm0    = mag(det_q);
    nm0[0] = mag(nu_q);
    nm0[1] = mag(nv_q);
    nm0[2] = mag(nt_q);
    sg0[0] = nu_q[A-1] ^ det_q[A-1];
    sg0[1] = nv_q[A-1] ^ det_q[A-1];
    sg0[2] = nt_q[A-1] ^ det_q[A-1];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      xp_q <= xp_d;
      e1_q <= in_item_i;
      hv_q[0] <= fix_x(xp_q[0]) - fix_x(xp_q[1]);
      hv_q[1] <= fix_x(xp_q[2]) - fix_x(xp_q[3]);
      hv_q[2] <= fix_x(xp_q[4]) - fix_x(xp_q[5]);
      kv_q[0] <= fix_x(xp_q[6]) - fix_x(xp_q[7]);
      kv_q[1] <= fix_x(xp_q[8]) - fix_x(xp_q[9]);
      kv_q[2] <= fix_x(xp_q[10]) - fix_x(xp_q[11]);
      e2_q <= e1_q;
      lo_q <= lo_d;
      hi_q <= hi_d;
      det_q <= fix_d(hi_q[0], lo_q[0]) + fix_d(hi_q[1], lo_q[1]) + fix_d(hi_q[2], lo_q[2]);
      nu_q  <= fix_d(hi_q[3], lo_q[3]) + fix_d(hi_q[4], lo_q[4]) + fix_d(hi_q[5], lo_q[5]);
      nv_q  <= fix_d(hi_q[6], lo_q[6]) + fix_d(hi_q[7], lo_q[7]) + fix_d(hi_q[8], lo_q[8]);
      nt_q  <= fix_d(hi_q[9], lo_q[9]) + fix_d(hi_q[10], lo_q[10])
             + fix_d(hi_q[11], lo_q[11]);
      dm_q[0]   <= dm0;
      miss_q[0] <= (dm0 == '0) || (dm0 < A'(cfg_i.det_epsilon));
      for (int l = 0; l < 3; l++) begin
        rem_q[0][l] <= '0;
        z_q[0][l]   <= {nm0[l], F'(0)};
        neg_q[0][l] <= sg0[l];
      end
    end
  end

  for (genvar k = 1; k <= Q; k++) begin : g_div
    logic [A:0]   rs [3];
    logic [A:0]   rn [3];
    logic         ge [3];

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        rs[l] = {rem_q[k-1][l], z_q[k-1][l][Q-1]};
        rn[l] = rs[l] - {1'b0, dm_q[k-1]};
        ge[l] = rs[l] >= {1'b0, dm_q[k-1]};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dm_q[k]   <= dm_q[k-1];
        miss_q[k] <= miss_q[k-1];
        for (int l = 0; l < 3; l++) begin
          rem_q[k][l] <= ge[l] ? rn[l][A-1:0] : rs[l][A-1:0];
          z_q[k][l]   <= {z_q[k-1][l][Q-2:0], ge[l]};
          neg_q[k][l] <= neg_q[k-1][l];
        end
      end
    end
  end

  // result checks and t saturation
  logic [A-1:0] qm [3];
  logic         u_bad, v_bad, hit;
  coord_t       t_val;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      qm[l] = (z_q[Q][l] > CAP) ? CAP[A-1:0] : z_q[Q][l][A-1:0];
    end
    // a quotient that truncates to zero is not negative
    u_bad = (neg_q[Q][0] && qm[0] != '0) || (!neg_q[Q][0] && qm[0] > ONE_FIX);
    v_bad = (neg_q[Q][1] && qm[1] != '0) || (qm[0] + qm[1] > ONE_FIX);
    hit   = !miss_q[Q] && !u_bad && !v_bad;
    if (!neg_q[Q][2]) begin
      t_val = (qm[2] > T_MAX) ? T_MAX[C-1:0] : qm[2][C-1:0];
    end else begin
      t_val = (qm[2] > T_MIN_MAG) ? T_MIN_MAG[C-1:0] : (C'(0) - qm[2][C-1:0]);
    end
    out_item_d.hit        = hit;
    out_item_d.distance_t = hit ? t_val : '0;
    out_item_d.bary_u     = hit ? qm[0][UV_BITS-1:0] : '0;
    out_item_d.bary_v     = hit ? qm[1][UV_BITS-1:0] : '0;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_item_q <= out_item_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q      <= '0;
      dv_q      <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      pv_q      <= {pv_q[3:1], in_valid_i};
      dv_q      <= {dv_q[Q-1:0], pv_q[4]};
      out_vld_q <= dv_q[Q];
    end
  end

  `RTI_ASSERT(a_miss_zero,
              (out_vld_q && !out_item_q.hit) |->
              (out_item_q.distance_t == '0 && out_item_q.bary_u == '0 &&
               out_item_q.bary_v == '0),
              "miss beat carries nonzero t, u or v")
  `RTI_ASSERT(a_hit_bary,
              (out_vld_q && out_item_q.hit) |->
              (({1'b0, out_item_q.bary_u} + {1'b0, out_item_q.bary_v}) <=
               (UV_BITS + 1)'(ONE_FIX)),
              "hit beat with u plus v above one")

endmodule

// ===== rtl/ray_triangle_intersect_core.sv =====
`timescale 1ns / 1ps
// Two-sided Moller-Trumbore ray/triangle test in signed Q16.16. Each input beat
// carries a ray origin and three vertices; the ray direction and the determinant
// threshold come from the APB registers (dir_x, dir_y, dir_z at 0x0, 0x4, 0x8,
// det_epsilon at 0xC), which the user must write only while the block is idle;
// the block itself does not enforce this. While the output is not stalled, one
// beat is accepted per cycle and one result beat leaves per cycle, back to back.
// A result beat passes the front register and the queue, the products and sums,
// the divider load, the restoring divider that resolves one quotient bit per
// stage for u, v and t in parallel, and the output register. A stalled output
// holds the whole back pipeline. A miss returns hit low with t, u and v zero.
module ray_triangle_intersect_core import rti_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_item_t             in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_item_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready
);

  cfg_t       cfg_q;
  reg_idx_e   idx;
  logic       wr;
  logic       fe_valid, fe_stall, bk_valid, bk_stall;
  edge_item_t fe_item, bk_item;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[ADDR_BITS-1:2]);
  assign wr     = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dir_x       <= DIR_X_RESET;
      cfg_q.dir_y       <= DIR_Y_RESET;
      cfg_q.dir_z       <= DIR_Z_RESET;
      cfg_q.det_epsilon <= DET_EPS_RESET;
    end else if (wr) begin
      unique case (idx)
        REG_DIR_X:   cfg_q.dir_x       <= pwdata[COORD_BITS-1:0];
        REG_DIR_Y:   cfg_q.dir_y       <= pwdata[COORD_BITS-1:0];
        REG_DIR_Z:   cfg_q.dir_z       <= pwdata[COORD_BITS-1:0];
        REG_DET_EPS: cfg_q.det_epsilon <= pwdata[EPS_BITS-1:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_DIR_X:   prdata = DATA_BITS'(cfg_q.dir_x);
      REG_DIR_Y:   prdata = DATA_BITS'(cfg_q.dir_y);
      REG_DIR_Z:   prdata = DATA_BITS'(cfg_q.dir_z);
      REG_DET_EPS: prdata = DATA_BITS'(cfg_q.det_epsilon);
      default:     prdata = '0;
    endcase
  end

  rti_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_item_i    (in_item_i),
    .edge_valid_o (fe_valid),
    .edge_stall_i (fe_stall),
    .edge_item_o  (fe_item)
  );

  rti_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fe_valid),
    .push_stall_o (fe_stall),
    .push_item_i  (fe_item),
    .pop_valid_o  (bk_valid),
    .pop_stall_i  (bk_stall),
    .pop_item_o   (bk_item)
  );

  rti_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (bk_valid),
    .in_stall_o  (bk_stall),
    .in_item_i   (bk_item),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
